// ===== src/sjf_pkg.sv =====
// Shared types and constants for the shortest-job-first ordering block.
// Used by sjf_ctrl, sjf_dp and shortest_job_first_order; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sjf_pkg;

	// Store depth and derived index/counter widths
	localparam int MAX_JOBS = 16;
	localparam int IDX_W = $clog2(MAX_JOBS);
	localparam int CNT_W = $clog2(MAX_JOBS + 1);
	localparam int ID_SUM_W = IDX_W + 1;

	// Field widths
	localparam int BURST_W = 16;
	localparam int ID_W = 5;
	localparam int FIN_W = 20;
	localparam int SUM_W = 24;
	localparam int FIN_RAW_W = BURST_W + IDX_W;
	localparam int FIN_ACC_W = (FIN_RAW_W > FIN_W) ? FIN_RAW_W : FIN_W;

	// Output tdata packing: id, burst, finish, sum, then zero fill
	localparam int RES_W = ID_W + BURST_W + FIN_W + SUM_W;
	localparam int TDATA_W = ((RES_W + 7) / 8) * 8;
	localparam int PAD_W = TDATA_W - RES_W;

	// One store entry: burst time and 0-based load position
	typedef struct packed {
		logic [BURST_W-1:0] burst;
		logic [IDX_W-1:0]   idx;
	} entry_t;

	// Controller states
	typedef enum logic [2:0] {
		ST_LOAD,
		ST_ROW,
		ST_HOLD,
		ST_SCAN,
		ST_WB,
		ST_EMIT_RD,
		ST_EMIT_OUT
	} state_t;

	// Store read address select
	typedef enum logic [1:0] {
		RD_I,
		RD_J,
		RD_J_NEXT,
		RD_K
	} rd_sel_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic    load;
		logic    row;
		logic    hold;
		logic    scan;
		logic    wb;
		logic    emit;
		rd_sel_t rd_sel;
	} sjf_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic first_job;
		logic j_end;
		logic i_end;
		logic k_end;
		logic out_free;
	} sjf_stat_t;

endpackage

`default_nettype wire

// ===== src/shortest_job_first_order.sv =====
// Top level of the shortest-job-first ordering block.
// Instantiates sjf_ctrl and sjf_dp; depends on sjf_pkg.
//
//  channel | direction | tdata                   | tuser    | tlast
//  s_axis  | in        | burst_time              | -        | last_job
//  m_axis  | out       | job_id, job_burst,      | overflow | last_result
//          |           | finish_time, finish_sum |          |
//
// On the last job the stored set of n jobs is exchange-sorted through one
// store read port: each row runs ST_ROW, ST_HOLD, one ST_SCAN per later
// entry and ST_WB. Each result is read in ST_EMIT_RD, sent in ST_EMIT_OUT;
// m_axis_tready can stall the read. The next set loads while the final
// result still waits in the output register. Reset clears the job count and
// drop flag at once; the store needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module shortest_job_first_order (
	input  wire                           clk,
	input  wire                           arst_n,
	// s_axis
	input  wire                           s_axis_tvalid,
	output logic                          s_axis_tready,
	input  wire [sjf_pkg::BURST_W-1:0]    s_axis_tdata,  // [15:0] burst_time
	input  wire                           s_axis_tlast,
	// m_axis
	output logic                          m_axis_tvalid,
	input  wire                           m_axis_tready,
	// [4:0] job_id, [20:5] job_burst, [40:21] finish_time,
	// [64:41] finish_sum, [71:65] zero
	output logic [sjf_pkg::TDATA_W-1:0]   m_axis_tdata,
	output logic                          m_axis_tuser,  // [0] overflow
	output logic                          m_axis_tlast
);
	import sjf_pkg::*;

	sjf_cmd_t  cmd;
	sjf_stat_t stat;

	// Sequencer
	sjf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_last  (s_axis_tlast),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Store, sort and emission datapath
	sjf_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_burst  (s_axis_tdata),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_ovf   (m_axis_tuser),
		.out_last  (m_axis_tlast)
	);

endmodule

`default_nettype wire

// ===== src/sjf_ctrl.sv =====
// Controller state machine for the shortest-job-first ordering block.
// Depends on sjf_pkg for state, command and status types.
`timescale 1ns / 1ps
`default_nettype none

module sjf_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	input  wire               in_last,
	output logic              in_ready,
	input  sjf_pkg::sjf_stat_t stat,
	output sjf_pkg::sjf_cmd_t  cmd
);
	import sjf_pkg::*;

	state_t state_q;
	state_t state_nxt;
	logic   accept;

	assign accept = in_valid && (state_q == ST_LOAD);

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (accept && in_last) begin
					state_nxt = stat.first_job ? ST_EMIT_RD : ST_ROW;
				end
			end
			ST_ROW:  state_nxt = ST_HOLD;
			ST_HOLD: state_nxt = ST_SCAN;
			ST_SCAN: begin
				if (stat.j_end) begin
					state_nxt = ST_WB;
				end
			end
			ST_WB: begin
				state_nxt = stat.i_end ? ST_EMIT_RD : ST_ROW;
			end
			ST_EMIT_RD: begin
				if (stat.out_free) begin
					state_nxt = ST_EMIT_OUT;
				end
			end
			ST_EMIT_OUT: begin
				state_nxt = stat.k_end ? ST_LOAD : ST_EMIT_RD;
			end
			default: state_nxt = ST_LOAD;
		endcase
	end

	// Outputs
	always_comb begin
		in_ready   = 1'b0;
		cmd        = '0;
		cmd.rd_sel = RD_K;
		unique case (state_q)
			ST_LOAD: begin
				in_ready = 1'b1;
				cmd.load = accept;
			end
			ST_ROW: begin
				cmd.row    = 1'b1;
				cmd.rd_sel = RD_I;
			end
			ST_HOLD: begin
				cmd.hold   = 1'b1;
				cmd.rd_sel = RD_J;
			end
			ST_SCAN: begin
				cmd.scan   = 1'b1;
				cmd.rd_sel = RD_J_NEXT;
			end
			ST_WB: begin
				cmd.wb = 1'b1;
			end
			ST_EMIT_RD: begin
				cmd.rd_sel = RD_K;
			end
			ST_EMIT_OUT: begin
				cmd.emit = 1'b1;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

`default_nettype wire

// ===== src/sjf_dp.sv =====
// Datapath for the shortest-job-first ordering block: job store, sort
// holding register, index counters, finish accumulators and output register.
// Depends on sjf_pkg for widths, entry and command/status types.
`timescale 1ns / 1ps
`default_nettype none

module sjf_dp (
	input  wire                             clk,
	input  wire                             arst_n,
	input  sjf_pkg::sjf_cmd_t               cmd,
	output sjf_pkg::sjf_stat_t              stat,
	input  wire [sjf_pkg::BURST_W-1:0]      in_burst,
	output logic                            out_valid,
	input  wire                             out_ready,
	output logic [sjf_pkg::TDATA_W-1:0]     out_data,
	output logic                            out_ovf,
	output logic                            out_last
);
	import sjf_pkg::*;

	// Job store: one write port, one registered read port
	entry_t mem [MAX_JOBS];
	entry_t rdata_q;
	logic [IDX_W-1:0] rd_addr;
	logic [IDX_W-1:0] wr_addr;
	entry_t           wr_data;
	logic             wr_en;

	// Control and index registers
	logic [CNT_W-1:0] count_q;
	logic             dropped_q;
	logic [IDX_W-1:0] i_q;
	logic [IDX_W-1:0] j_q;
	logic [IDX_W-1:0] k_q;
	entry_t           held_q;

	// Emission accumulators and output register
	logic [FIN_ACC_W-1:0] fin_acc_q;
	logic [SUM_W-1:0]     sum_q;
	logic [FIN_ACC_W-1:0] fin_nxt;
	logic [SUM_W-1:0]     sum_nxt;
	logic                 out_valid_q;
	logic [ID_W-1:0]      out_id_q;
	logic [BURST_W-1:0]   out_burst_q;
	logic [FIN_W-1:0]     out_fin_q;
	logic [SUM_W-1:0]     out_sum_q;
	logic                 out_ovf_q;
	logic                 out_last_q;

	logic full;
	logic swap;
	logic [IDX_W-1:0] j_next;

	assign full   = (count_q == CNT_W'(MAX_JOBS));
	assign swap   = (rdata_q.burst < held_q.burst);
	assign j_next = IDX_W'(j_q + 1'b1);

	// Status toward the controller
	assign stat.first_job = (count_q == '0);
	assign stat.j_end     = ((CNT_W'(j_q) + CNT_W'(1)) == count_q);
	assign stat.i_end     = ((CNT_W'(i_q) + CNT_W'(2)) == count_q);
	assign stat.k_end     = ((CNT_W'(k_q) + CNT_W'(1)) == count_q);
	assign stat.out_free  = !out_valid_q || out_ready;

	// Read address select
	always_comb begin
		case (cmd.rd_sel)
			RD_I:      rd_addr = i_q;
			RD_J:      rd_addr = j_q;
			RD_J_NEXT: rd_addr = j_next;
			RD_K:      rd_addr = k_q;
			default:   rd_addr = k_q;
		endcase
	end

	// Write port: load, swap during scan, write back held entry at row end
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = i_q;
		wr_data = held_q;
		if (cmd.load) begin
			wr_en       = !full;
			wr_addr     = count_q[IDX_W-1:0];
			wr_data.burst = in_burst;
			wr_data.idx   = count_q[IDX_W-1:0];
		end else if (cmd.scan) begin
			wr_en   = swap;
			wr_addr = j_q;
		end else if (cmd.wb) begin
			wr_en   = 1'b1;
			wr_addr = i_q;
		end
	end

	// Store array
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rdata_q <= mem[rd_addr];
	end

	// Load count and drop flag; clear after the final result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			dropped_q <= 1'b0;
		end else if (cmd.load) begin
			if (full) begin
				dropped_q <= 1'b1;
			end else begin
				count_q <= count_q + CNT_W'(1);
			end
		end else if (cmd.emit && stat.k_end) begin
			count_q   <= '0;
			dropped_q <= 1'b0;
		end
	end

	// Sort row and column indices, emission index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
		end else begin
			if (cmd.load) begin
				i_q <= '0;
				k_q <= '0;
			end
			if (cmd.row) begin
				j_q <= IDX_W'(i_q + 1'b1);
			end
			if (cmd.scan) begin
				j_q <= j_next;
			end
			if (cmd.wb) begin
				i_q <= IDX_W'(i_q + 1'b1);
			end
			if (cmd.emit) begin
				k_q <= IDX_W'(k_q + 1'b1);
			end
		end
	end

	// Holding register: smallest entry seen so far in the current row
	always_ff @(posedge clk) begin
		if (cmd.hold || (cmd.scan && swap)) begin
			held_q <= rdata_q;
		end
	end

	// Running finish time and finish-time sum
	assign fin_nxt = fin_acc_q + FIN_ACC_W'(rdata_q.burst);
	assign sum_nxt = sum_q + SUM_W'(fin_nxt);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			fin_acc_q <= '0;
			sum_q     <= '0;
		end else if (cmd.emit) begin
			fin_acc_q <= fin_nxt;
			sum_q     <= sum_nxt;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_id_q    <= ID_W'(ID_SUM_W'(rdata_q.idx) + ID_SUM_W'(1));
			out_burst_q <= rdata_q.burst;
			out_fin_q   <= FIN_W'(fin_nxt);
			out_sum_q   <= stat.k_end ? sum_nxt : '0;
			out_ovf_q   <= dropped_q;
			out_last_q  <= stat.k_end;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = {{PAD_W{1'b0}}, out_sum_q, out_fin_q, out_burst_q, out_id_q};
	assign out_ovf   = out_ovf_q;
	assign out_last  = out_last_q;

endmodule

`default_nettype wire

// ===== dv/tb_shortest_job_first_order.sv =====
`timescale 1ns / 1ps
// Testbench for shortest_job_first_order: feeds sets of job bursts over s_axis and
// checks every served job on m_axis against an in-bench SJF ordering predictor.
// Depends on sjf_pkg and the RTL of the block; needs nothing else.

module tb_shortest_job_first_order;
	import sjf_pkg::*;

	localparam int CLK_HALF     = 5;
	localparam int RESET_CYCLES = 11;
	localparam int RAND_LOADS   = 445;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 200;
	localparam int CYCLE_LIMIT  = 300000;

	// m_axis tdata field offsets
	localparam int ID_LSB    = 0;
	localparam int BURST_LSB = ID_LSB + ID_W;
	localparam int FIN_LSB   = BURST_LSB + BURST_W;
	localparam int SUM_LSB   = FIN_LSB + FIN_W;

	typedef struct packed {
		logic [ID_W-1:0]    id;
		logic [BURST_W-1:0] burst;
		logic [FIN_W-1:0]   finish;
		logic [SUM_W-1:0]   sum;
		logic               overflow;
		logic               last;
	} served_job_t;

	// One load on s_axis; res is the typed-in result when fixed is set
	typedef struct packed {
		logic [BURST_W-1:0] burst;
		logic               last;
		logic               fixed;
		served_job_t        res;
	} job_load_t;

	// Directed row: reps copies of one load
	typedef struct packed {
		logic [BURST_W-1:0] burst;
		logic               last;
		logic [4:0]         reps;
		logic               fixed;
		served_job_t        res;
	} dir_row_t;

	typedef enum int {
		BM_WIDE,
		BM_TIES,
		BM_EDGE
	} burst_mode_t;

	localparam int N_DIR = 10;
	localparam served_job_t NO_RES = '0;

	dir_row_t dir_tab [N_DIR] = '{
		// single zero-length job
		'{16'h0000, 1'b1, 5'd1, 1'b1, '{5'd1, 16'h0000, 20'h00000, 24'h000000, 1'b0, 1'b1}},
		// single longest job
		'{16'hFFFF, 1'b1, 5'd1, 1'b1, '{5'd1, 16'hFFFF, 20'h0FFFF, 24'h00FFFF, 1'b0, 1'b1}},
		// equal bursts behind a shorter job come out in reverse load order
		'{16'h0005, 1'b0, 5'd2, 1'b0, NO_RES},
		'{16'h0003, 1'b1, 5'd1, 1'b0, NO_RES},
		// full store of longest jobs, closing load dropped: max finish and sum
		'{16'hFFFF, 1'b0, 5'd16, 1'b0, NO_RES},
		'{16'h1234, 1'b1, 5'd1, 1'b0, NO_RES},
		// descending bursts come out reversed
		'{16'h0009, 1'b0, 5'd1, 1'b0, NO_RES},
		'{16'h0007, 1'b0, 5'd1, 1'b0, NO_RES},
		'{16'h0000, 1'b1, 5'd1, 1'b0, NO_RES},
		// single unit job
		'{16'h0001, 1'b1, 5'd1, 1'b1, '{5'd1, 16'h0001, 20'h00001, 24'h000001, 1'b0, 1'b1}}
	};

	logic                 clk;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [BURST_W-1:0]   s_axis_tdata;   // [15:0] burst_time
	logic                 s_axis_tlast;   // last_job
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	// [4:0] job_id, [20:5] job_burst, [40:21] finish_time, [64:41] finish_sum, [71:65] zero
	logic [TDATA_W-1:0]   m_axis_tdata;
	logic                 m_axis_tuser;   // [0] overflow
	logic                 m_axis_tlast;   // last_result

	shortest_job_first_order dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	job_load_t          load_q [$];
	served_job_t        served_q [$];
	served_job_t        want;
	logic [BURST_W-1:0] pend_burst [MAX_JOBS];
	logic [ID_W-1:0]    pend_id [MAX_JOBS];
	int                 pend_cnt;
	bit                 pend_drop;
	int                 accept_idx;
	int                 phase;
	bit                 sender_done;
	int                 fail_cnt;
	int                 sets_closed;
	int                 loads_dropped;
	int                 results_checked;
	int                 cycle_cnt;

	// Load one accepted job; on the closing load, order the set and queue its results
	task automatic sjf_take(input job_load_t ld);
		logic [BURST_W-1:0] tmp_burst;
		logic [ID_W-1:0]    tmp_id;
		int unsigned        fin;
		int unsigned        total;
		served_job_t        r;
		if (pend_cnt < MAX_JOBS) begin
			pend_burst[pend_cnt] = ld.burst;
			pend_id[pend_cnt] = ID_W'(pend_cnt + 1);
			pend_cnt++;
		end else begin
			pend_drop = 1'b1;
			loads_dropped++;
		end
		if (ld.last) begin
			// exchange sort, swap only on strictly smaller burst
			for (int i = 0; i + 1 < pend_cnt; i++) begin
				for (int j = i + 1; j < pend_cnt; j++) begin
					if (pend_burst[j] < pend_burst[i]) begin
						tmp_burst = pend_burst[j];
						tmp_id = pend_id[j];
						pend_burst[j] = pend_burst[i];
						pend_id[j] = pend_id[i];
						pend_burst[i] = tmp_burst;
						pend_id[i] = tmp_id;
					end
				end
			end
			fin = 0;
			total = 0;
			for (int k = 0; k < pend_cnt; k++) begin
				fin += pend_burst[k];
				total += fin;
				r.id = pend_id[k];
				r.burst = pend_burst[k];
				r.finish = FIN_W'(fin);
				r.sum = (k == pend_cnt - 1) ? SUM_W'(total) : '0;
				r.overflow = pend_drop;
				r.last = (k == pend_cnt - 1);
				if (!ld.fixed)
					served_q.push_back(r);
			end
			if (ld.fixed)
				served_q.push_back(ld.res);
			pend_cnt = 0;
			pend_drop = 1'b0;
			sets_closed++;
		end
	endtask

	task automatic check_field(input string name, input int unsigned exp_v,
			input int unsigned act_v);
		if (exp_v !== act_v) begin
			$error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
			fail_cnt++;
		end
	endtask

	// Clock and reset
	initial clk = 1'b0;
	always #CLK_HALF clk = ~clk;

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		m_axis_tready = 1'b0;
		pend_cnt = 0;
		pend_drop = 1'b0;
		accept_idx = 0;
		phase = 0;
		sender_done = 1'b0;
		fail_cnt = 0;
		sets_closed = 0;
		loads_dropped = 0;
		results_checked = 0;
		cycle_cnt = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results still pending",
				cycle_cnt, served_q.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	// Build the stimulus, then offer each load with random idle cycles
	initial begin : sender
		job_load_t   ld;
		int          n;
		int          added;
		int          idx;
		int          idle_pct;
		burst_mode_t mode;
		for (int r = 0; r < N_DIR; r++) begin
			for (int k = 0; k < dir_tab[r].reps; k++) begin
				ld.burst = dir_tab[r].burst;
				ld.last = dir_tab[r].last && (k == dir_tab[r].reps - 1);
				ld.fixed = dir_tab[r].fixed;
				ld.res = dir_tab[r].res;
				load_q.push_back(ld);
			end
		end
		added = 0;
		while (added < RAND_LOADS) begin
			// mostly sets that fit, some that overrun the store
			if ($urandom_range(0, 9) == 0)
				n = $urandom_range(MAX_JOBS + 1, MAX_JOBS + 4);
			else
				n = $urandom_range(1, MAX_JOBS);
			mode = burst_mode_t'($urandom_range(0, 2));
			for (int k = 0; k < n; k++) begin
				ld = '0;
				case (mode)
					BM_WIDE: begin
						ld.burst = BURST_W'($urandom);
					end
					BM_TIES: begin
						ld.burst = BURST_W'($urandom_range(0, 3));
					end
					default: begin
						case ($urandom_range(0, 3))
							0: ld.burst = '0;
							1: ld.burst = 16'h0001;
							2: ld.burst = 16'hFFFE;
							default: ld.burst = 16'hFFFF;
						endcase
					end
				endcase
				ld.last = (k == n - 1);
				load_q.push_back(ld);
			end
			added += n;
		end

		wait (arst_n === 1'b1);
		idx = 0;
		while (idx < load_q.size()) begin
			@(posedge clk);
			phase = (idx * 3) / load_q.size();
			idle_pct = (phase == 0) ? 19 : (phase == 1) ? 52 : 0;
			if (!s_axis_tvalid || s_axis_tready) begin
				if ($urandom_range(0, 99) < idle_pct) begin
					s_axis_tvalid <= 1'b0;
				end else begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= load_q[idx].burst;
					s_axis_tlast <= load_q[idx].last;
					idx++;
				end
			end
		end
		// hold the final load until taken
		do @(posedge clk); while (!s_axis_tready);
		s_axis_tvalid <= 1'b0;
		sender_done = 1'b1;
	end

	// Receiver: random back-pressure, one long hold-off once idling stops
	initial begin : receiver
		int  hold_cnt;
		int  idle_pct;
		bit  held;
		held = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (phase == 2 && !held) begin
				held = 1'b1;
				hold_cnt = 0;
				m_axis_tready <= 1'b0;
				while (hold_cnt < HOLD_CYCLES) begin
					@(posedge clk);
					hold_cnt++;
				end
			end
			idle_pct = (phase == 0) ? 52 : (phase == 1) ? 19 : 0;
			m_axis_tready <= ($urandom_range(0, 99) >= idle_pct);
		end
	end

	// Predict on each accepted load transaction
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			sjf_take(load_q[accept_idx]);
			accept_idx++;
		end
	end

	// Check each accepted result transaction against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (served_q.size() == 0) begin
				$error("unexpected result: tdata %h tuser %b tlast %b",
					m_axis_tdata, m_axis_tuser, m_axis_tlast);
				fail_cnt++;
			end else begin
				want = served_q.pop_front();
				results_checked++;
				check_field("job_id", want.id, m_axis_tdata[ID_LSB +: ID_W]);
				check_field("job_burst", want.burst, m_axis_tdata[BURST_LSB +: BURST_W]);
				check_field("finish_time", want.finish, m_axis_tdata[FIN_LSB +: FIN_W]);
				check_field("finish_sum", want.sum, m_axis_tdata[SUM_LSB +: SUM_W]);
				check_field("tdata_pad", 0, m_axis_tdata[TDATA_W-1:RES_W]);
				check_field("overflow", want.overflow, m_axis_tuser);
				check_field("last_result", want.last, m_axis_tlast);
			end
		end
	end

	// Drain, then report
	initial begin : finish_ctl
		wait (sender_done);
		// let the predictor take the final load transaction first
		@(posedge clk);
		while (served_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Ran %0d job loads in %0d sets (%0d loads dropped on a full store)",
			load_q.size(), sets_closed, loads_dropped);
		$display("Checked %0d served jobs under mixed and long back-pressure", results_checked);
		if (fail_cnt == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
